FILE: hdl/srs_pkg.sv
// shared types and constants for the selective repeat sender
`timescale 1ns / 1ps
package srs_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int MAX_WINDOW = 16;

    // address into the acknowledged map, frame counter width
    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int WW = $clog2(MAX_WINDOW + 1);

    // fixed field widths
    localparam int TOTAL_W = 9;
    localparam int WIN_W   = 5;
    localparam int SEQ_W   = 8;
    localparam int ACK_W   = 16;

    typedef enum logic [1:0] {
        CMD_ACK     = 2'd0,
        CMD_TIMEOUT = 2'd1,
        CMD_POLL    = 2'd2,
        CMD_POLL_X  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        K_SEND    = 3'd0,
        K_RESEND  = 3'd1,
        K_ACK_OK  = 3'd2,
        K_ACK_BAD = 3'd3,
        K_TIMEOUT = 3'd4,
        K_DONE    = 3'd5,
        K_POLL    = 3'd6
    } t_kind;

    typedef enum logic [0:0] {
        REG_TOTAL  = 1'b0,
        REG_WINDOW = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        SEQ_ZERO,
        SEQ_NEXT,
        SEQ_ACK,
        SEQ_IDX
    } t_seq_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEND,
        S_EVT,
        S_SL_RD,
        S_SL_CHK,
        S_RS_RD,
        S_RS_CHK
    } t_state;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ACK_W-1:0] ack_seq;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [SEQ_W-1:0] seq_no;
        logic             last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     do_send;
        logic     do_mark;
        logic     do_slide;
        logic     rs_init;
        logic     rs_next;
        logic     rd_idx;
        logic     emit;
        t_kind    kind;
        t_seq_sel seq_sel;
        logic     last;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic can_send;
        logic ack_ok;
        logic ack_is_base;
        logic sl_more;
        logic rs_more;
        logic rd_acked;
        logic out_free;
        t_cmd cmd;
    } t_stat;

endpackage

FILE: hdl/selective_repeat_sender.sv
// top level of the selective repeat sender
//
// usage
//   input channel (i_in_valid / o_in_stall / i_in_item) carries one event beat:
//   ack received, timeout, or poll. a beat is taken when valid is high and
//   stall is low. each event first sends new frames until the window from
//   base is full or all frames are sent, then handles it; done if all acked.
//   output channel (o_out_valid / i_out_stall / o_out_item) gives result beats,
//   the last one of each event flagged by last.
//   config channel (i_cfg_valid / o_cfg_ready) writes total_frames (index 0)
//   or window_size (index 1); write only while no event is in flight.
// timing
//   one event is processed at a time; stall stays high until it finishes.
//   an event passes the start state, then the send and event states unless the
//   transfer is done. a timeout walk, or a slide of the base past acknowledged
//   frames, alternates a read and a check state per frame, set by the
//   registered read of the acknowledged map ram. the longest case is a full
//   window of 16 sends followed by a 16-frame resend walk.
// reset
//   synchronous, active low: base and next go to 0, the acknowledged map
//   reads all zero at once through per-entry valid flops, config to 10 and 4.
// a stalled receiver holds the result register and pauses the sequencer
`timescale 1ns / 1ps
module selective_repeat_sender import srs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // event beats
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    // config writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [TOTAL_W-1:0] i_cfg_data
);

    t_ctl  ctl;
    t_stat stat;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: fill window, then ack / timeout / poll handling
    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // pointers, acknowledged map, config and result register
    srs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: hdl/srs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module srs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/srs_datapath.sv
// window pointers, acknowledged map, config registers and result register
`timescale 1ns / 1ps
module srs_datapath import srs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_in_item           i_in_item,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [TOTAL_W-1:0] i_cfg_data,
    input  t_ctl               i_ctl,
    output t_stat              o_stat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item
);

    logic [TOTAL_W-1:0] r_total;
    logic [WIN_W-1:0]   r_win;
    logic [1:0]         r_cmd;
    logic [ACK_W-1:0]   r_ack;
    logic [CW-1:0]      r_base;
    logic [CW-1:0]      r_next;
    logic [CW-1:0]      r_idx;
    logic [MAX_FRAMES-1:0] r_vld;
    logic               r_rd_vld;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CW-1:0]      eff_total;
    logic [WW-1:0]      eff_win;
    logic [CW:0]        lim;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic               rd_data;
    logic               out_free;
    logic [SEQ_W-1:0]   seq;

    // saturate the config into legal ranges
    always_comb begin
        if (int'(r_total) > MAX_FRAMES) begin
            eff_total = CW'(MAX_FRAMES);
        end else begin
            eff_total = CW'(r_total);
        end
        if (r_win == '0) begin
            eff_win = WW'(1);
        end else if (int'(r_win) > MAX_WINDOW) begin
            eff_win = WW'(MAX_WINDOW);
        end else begin
            eff_win = WW'(r_win);
        end
    end

    assign lim      = {1'b0, r_base} + (CW+1)'(eff_win);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.done        = r_base >= eff_total;
        o_stat.can_send    = ({1'b0, r_next} < lim) && (r_next < eff_total);
        o_stat.ack_ok      = (int'(r_ack) < int'(eff_total)) && (int'(r_ack) < int'(r_next));
        o_stat.ack_is_base = int'(r_ack) == int'(r_base);
        o_stat.sl_more     = (r_base < eff_total) && (r_base < r_next);
        o_stat.rs_more     = (r_idx < eff_total) && (r_idx < r_next);
        o_stat.rd_acked    = r_rd_vld && rd_data;
        o_stat.out_free    = out_free;
        o_stat.cmd         = t_cmd'(r_cmd);
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_W'(10);
            r_win   <= WIN_W'(4);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == {1'b0, REG_TOTAL}) begin
                r_total <= i_cfg_data;
            end else if (i_cfg_index == {1'b0, REG_WINDOW}) begin
                r_win <= i_cfg_data[WIN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_in_item.cmd;
            r_ack <= i_in_item.ack_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_next <= '0;
            r_idx  <= '0;
        end else begin
            if ((i_ctl.do_mark && o_stat.ack_is_base) || i_ctl.do_slide) begin
                r_base <= r_base + CW'(1);
            end
            if (i_ctl.do_send) begin
                r_next <= r_next + CW'(1);
            end
            if (i_ctl.rs_init) begin
                r_idx <= r_base;
            end else if (i_ctl.rs_next) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    // acknowledged map: ram plus per-entry valid bits cleared at reset
    assign we    = i_ctl.do_send || i_ctl.do_mark;
    assign waddr = i_ctl.do_send ? r_next[AW-1:0] : r_ack[AW-1:0];
    assign raddr = i_ctl.rd_idx ? r_idx[AW-1:0] : r_base[AW-1:0];

    srs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_FRAMES)
    ) u_acked (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_ctl.do_mark),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[raddr];
        end
    end

    // result register
    always_comb begin
        case (i_ctl.seq_sel)
            SEQ_NEXT: seq = SEQ_W'(r_next);
            SEQ_ACK:  seq = r_ack[SEQ_W-1:0];
            SEQ_IDX:  seq = SEQ_W'(r_idx);
            default:  seq = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit && out_free) begin
            r_out.kind   <= i_ctl.kind;
            r_out.seq_no <= seq;
            r_out.last   <= i_ctl.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_base_le_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= r_next) else $error("window base passed next frame");

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next - r_base) <= CW'(MAX_WINDOW)) else $error("too many frames outstanding");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit |-> out_free) else $error("result issued while output register busy");

endmodule

FILE: hdl/srs_ctrl.sv
// sequencing state machine for the selective repeat sender
`timescale 1ns / 1ps
module srs_ctrl import srs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                if (!i_stat.done) n_state = S_SEND;
                else if (i_stat.out_free) n_state = S_IDLE;
            end
            S_SEND: begin
                if (!i_stat.can_send) n_state = S_EVT;
            end
            S_EVT: begin
                case (i_stat.cmd)
                    CMD_ACK: begin
                        if (i_stat.out_free) begin
                            if (i_stat.ack_ok && i_stat.ack_is_base) n_state = S_SL_RD;
                            else n_state = S_IDLE;
                        end
                    end
                    CMD_TIMEOUT: n_state = S_RS_RD;
                    default: begin
                        if (i_stat.out_free) n_state = S_IDLE;
                    end
                endcase
            end
            S_SL_RD: begin
                n_state = i_stat.sl_more ? S_SL_CHK : S_IDLE;
            end
            S_SL_CHK: begin
                n_state = i_stat.rd_acked ? S_SL_RD : S_IDLE;
            end
            S_RS_RD: begin
                if (i_stat.rs_more) n_state = S_RS_CHK;
                else if (i_stat.out_free) n_state = S_IDLE;
            end
            S_RS_CHK: begin
                if (i_stat.rd_acked || i_stat.out_free) n_state = S_RS_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_stall = r_state != S_IDLE;
        case (r_state)
            S_IDLE: begin
                o_ctl.load = i_in_valid;
            end
            S_START: begin
                if (i_stat.done && i_stat.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = K_DONE;
                    o_ctl.last = 1'b1;
                end
            end
            S_SEND: begin
                if (i_stat.can_send && i_stat.out_free) begin
                    o_ctl.do_send = 1'b1;
                    o_ctl.emit    = 1'b1;
                    o_ctl.kind    = K_SEND;
                    o_ctl.seq_sel = SEQ_NEXT;
                end
            end
            S_EVT: begin
                case (i_stat.cmd)
                    CMD_ACK: begin
                        if (i_stat.out_free) begin
                            o_ctl.emit = 1'b1;
                            o_ctl.last = 1'b1;
                            if (i_stat.ack_ok) begin
                                o_ctl.do_mark = 1'b1;
                                o_ctl.kind    = K_ACK_OK;
                                o_ctl.seq_sel = SEQ_ACK;
                            end else begin
                                o_ctl.kind = K_ACK_BAD;
                            end
                        end
                    end
                    CMD_TIMEOUT: o_ctl.rs_init = 1'b1;
                    default: begin
                        if (i_stat.out_free) begin
                            o_ctl.emit = 1'b1;
                            o_ctl.kind = K_POLL;
                            o_ctl.last = 1'b1;
                        end
                    end
                endcase
            end
            S_SL_RD: begin
                o_ctl.rd_idx = 1'b0;
            end
            S_SL_CHK: begin
                o_ctl.do_slide = i_stat.rd_acked;
            end
            S_RS_RD: begin
                o_ctl.rd_idx = 1'b1;
                if (!i_stat.rs_more && i_stat.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = K_TIMEOUT;
                    o_ctl.last = 1'b1;
                end
            end
            S_RS_CHK: begin
                o_ctl.rd_idx = 1'b1;
                if (i_stat.rd_acked) begin
                    o_ctl.rs_next = 1'b1;
                end else if (i_stat.out_free) begin
                    o_ctl.rs_next = 1'b1;
                    o_ctl.emit    = 1'b1;
                    o_ctl.kind    = K_RESEND;
                    o_ctl.seq_sel = SEQ_IDX;
                end
            end
            default: o_ctl = '0;
        endcase
    end

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.do_send, o_ctl.do_mark, o_ctl.do_slide}))
        else $error("conflicting map or pointer updates");

    a_resend_unacked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.emit && o_ctl.kind == K_RESEND) |-> !i_stat.rd_acked)
        else $error("resend of an acknowledged frame");

    a_load_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |-> (i_in_valid && !o_in_stall))
        else $error("payload loaded without an accepted beat");

endmodule
